// ----- design/cto_pkg.sv -----
// shared types and constants of the connection timeout queue
`default_nettype none
package cto_pkg;

  // fixed field widths
  localparam int CmdW       = 2;
  localparam int ConnFieldW = 16;
  localparam int SeqW       = 32;
  localparam int TimeW      = 32;
  localparam int WaitW      = 16;
  localparam int StatusW    = 3;
  localparam int CountW     = 6;
  localparam int MaxResults = 32;

  // commands
  typedef enum logic [CmdW-1:0] {
    CmdAdd   = 2'd0,
    CmdTick  = 2'd1,
    CmdDel   = 2'd2,
    CmdClear = 2'd3
  } cmd_e;

  // result status codes
  localparam logic [StatusW-1:0] StExpired = 3'd0;
  localparam logic [StatusW-1:0] StNone    = 3'd1;
  localparam logic [StatusW-1:0] StAdded   = 3'd2;
  localparam logic [StatusW-1:0] StFull    = 3'd3;
  localparam logic [StatusW-1:0] StDeleted = 3'd4;
  localparam logic [StatusW-1:0] StCleared = 3'd5;

  // configuration register indexes
  localparam logic RegWaitTime = 1'b0;
  localparam logic RegKick     = 1'b1;

  // what each cell of the chain does in a cycle
  typedef enum logic [1:0] {
    ModeHold   = 2'd0,
    ModeIns    = 2'd1,
    ModePop    = 2'd2,
    ModePopIns = 2'd3
  } mode_e;

  // broadcast control to all cells
  typedef struct packed {
    mode_e             mode;
    logic              tail_only;
    logic [TimeW-1:0]  key;
    logic [SeqW-1:0]   seq;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0]       cmd;
    logic [ConnFieldW-1:0] conn_id;
    logic [SeqW-1:0]       conn_seq;
    logic [TimeW-1:0]      now;
  } in_word_t;

  typedef struct packed {
    logic [StatusW-1:0]    status;
    logic [ConnFieldW-1:0] out_conn;
    logic [SeqW-1:0]       out_seq;
    logic [TimeW-1:0]      out_expiry;
    logic [CountW-1:0]     removed_count;
    logic [CountW-1:0]     held_count;
    logic [TimeW-1:0]      earliest;
    logic                  last;
  } out_word_t;

endpackage
`default_nettype wire

// ----- design/cto_stream_if.sv -----
// valid/ready stream interface carrying one word
`default_nettype none
interface cto_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/cto_cell.sv -----
// one cell of the sorted timer chain: holds one entry, trades with neighbors
`default_nettype none
module cto_cell #(
  parameter int IDX    = 0,
  parameter int CONN_W = 16,
  parameter int CNT_W  = 6
) (
  input  wire logic                      clk_i,
  input  wire cto_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [CNT_W-1:0]          cnt_i,
  input  wire logic [CONN_W-1:0]         new_conn_i,
  input  wire logic                      left_ins_i,
  input  wire logic [cto_pkg::TimeW-1:0] left_exp_i,
  input  wire logic [CONN_W-1:0]         left_conn_i,
  input  wire logic [cto_pkg::SeqW-1:0]  left_seq_i,
  input  wire logic [cto_pkg::TimeW-1:0] right_exp_i,
  input  wire logic [CONN_W-1:0]         right_conn_i,
  input  wire logic [cto_pkg::SeqW-1:0]  right_seq_i,
  output logic                           ins_o,
  output logic [cto_pkg::TimeW-1:0]      exp_o,
  output logic [CONN_W-1:0]              conn_o,
  output logic [cto_pkg::SeqW-1:0]       seq_o,
  output logic [cto_pkg::TimeW-1:0]      exp_d_o
);
  import cto_pkg::*;

  localparam logic [CNT_W-1:0] IdxC  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NextC = CNT_W'(IDX + 1);

  logic [TimeW-1:0]  exp_q, exp_d;
  logic [CONN_W-1:0] conn_q, conn_d;
  logic [SeqW-1:0]   seq_q, seq_d;
  logic              here_free, next_free;

  assign here_free = (IdxC >= cnt_i);
  assign next_free = (NextC >= cnt_i);

  // insert point: first cell whose entry sorts after the new key
  always_comb begin
    ins_o  = 1'b0;
    exp_d  = exp_q;
    conn_d = conn_q;
    seq_d  = seq_q;
    case (ctrl_i.mode)
      ModeIns: begin
        ins_o = here_free || (exp_q > ctrl_i.key);
        if (ins_o && !left_ins_i) begin
          exp_d  = ctrl_i.key;
          conn_d = new_conn_i;
          seq_d  = ctrl_i.seq;
        end else if (left_ins_i) begin
          exp_d  = left_exp_i;
          conn_d = left_conn_i;
          seq_d  = left_seq_i;
        end
      end
      ModePopIns: begin
        // view after the head leaves: this cell would hold its right neighbor
        ins_o = next_free || (!ctrl_i.tail_only && (right_exp_i > ctrl_i.key));
        if (ins_o && !left_ins_i) begin
          exp_d  = ctrl_i.key;
          conn_d = new_conn_i;
          seq_d  = ctrl_i.seq;
        end else if (!left_ins_i) begin
          exp_d  = right_exp_i;
          conn_d = right_conn_i;
          seq_d  = right_seq_i;
        end
      end
      ModePop: begin
        exp_d  = right_exp_i;
        conn_d = right_conn_i;
        seq_d  = right_seq_i;
      end
      default: begin
        ins_o = 1'b0;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    conn_q <= conn_d;
    seq_q  <= seq_d;
  end

  assign exp_o   = exp_q;
  assign conn_o  = conn_q;
  assign seq_o   = seq_q;
  assign exp_d_o = exp_d;
endmodule
`default_nettype wire

// ----- design/cto_chain.sv -----
// row of timer cells kept in ascending expiry order
`default_nettype none
module cto_chain #(
  parameter int CAPACITY = 32,
  parameter int CONN_W   = 16,
  parameter int CNT_W    = 6
) (
  input  wire logic                      clk_i,
  input  wire cto_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [CNT_W-1:0]          cnt_i,
  input  wire logic [CONN_W-1:0]         new_conn_i,
  output logic [cto_pkg::TimeW-1:0]      head_exp_o,
  output logic [CONN_W-1:0]              head_conn_o,
  output logic [cto_pkg::SeqW-1:0]       head_seq_o,
  output logic [cto_pkg::TimeW-1:0]      head_exp_d_o
);
  import cto_pkg::*;

  logic [TimeW-1:0]  exp_w   [CAPACITY];
  logic [CONN_W-1:0] conn_w  [CAPACITY];
  logic [SeqW-1:0]   seq_w   [CAPACITY];
  logic [TimeW-1:0]  exp_d_w [CAPACITY];
  logic              ins_w   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              l_ins;
    logic [TimeW-1:0]  l_exp, r_exp;
    logic [CONN_W-1:0] l_conn, r_conn;
    logic [SeqW-1:0]   l_seq, r_seq;

    // left neighbor, none for the head
    if (i == 0) begin : g_head
      assign l_ins  = 1'b0;
      assign l_exp  = '0;
      assign l_conn = '0;
      assign l_seq  = '0;
    end else begin : g_left
      assign l_ins  = ins_w[i-1];
      assign l_exp  = exp_w[i-1];
      assign l_conn = conn_w[i-1];
      assign l_seq  = seq_w[i-1];
    end

    // right neighbor, none for the tail
    if (i == CAPACITY - 1) begin : g_tail
      assign r_exp  = '0;
      assign r_conn = '0;
      assign r_seq  = '0;
    end else begin : g_right
      assign r_exp  = exp_w[i+1];
      assign r_conn = conn_w[i+1];
      assign r_seq  = seq_w[i+1];
    end

    cto_cell #(
      .IDX    (i),
      .CONN_W (CONN_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .cnt_i        (cnt_i),
      .new_conn_i   (new_conn_i),
      .left_ins_i   (l_ins),
      .left_exp_i   (l_exp),
      .left_conn_i  (l_conn),
      .left_seq_i   (l_seq),
      .right_exp_i  (r_exp),
      .right_conn_i (r_conn),
      .right_seq_i  (r_seq),
      .ins_o        (ins_w[i]),
      .exp_o        (exp_w[i]),
      .conn_o       (conn_w[i]),
      .seq_o        (seq_w[i]),
      .exp_d_o      (exp_d_w[i])
    );
  end

  assign head_exp_o   = exp_w[0];
  assign head_conn_o  = conn_w[0];
  assign head_seq_o   = seq_w[0];
  assign head_exp_d_o = exp_d_w[0];
endmodule
`default_nettype wire

// ----- design/connection_timeout_queue_top.sv -----
// Connection timeout queue: sorted timer queue built from a chain of cells.
// in_i takes command words (add, tick, delete connection, clear); out_o gives
// result words, one per command except a tick, which gives one word for each
// expired entry (earliest first) or a single "none expired" word. The final
// word of a command has last set. The cfg port writes wait_time (index 0) and
// kick_on_timeout (index 1); the user writes it only while the block is idle,
// which the block does not enforce. Timing: a word is taken only in idle; add
// and clear answer from their own state through the output register, a tick
// gives its first result the same way and then one result per cycle while the
// output does not stall, since each cell pops and re-inserts in one step.
// Delete rotates every held entry once through the chain, one entry a cycle,
// then answers. The next command is taken once the last result is registered.
// The output register holds a result while out_o.ready is low; the queue
// then waits before producing the next result.
// Reset empties the queue, sets wait_time to 20 and clears kick mode; no
// clearing pass is needed since entries past the count are never read.
`default_nettype none
module connection_timeout_queue_top #(
  parameter int CAPACITY  = 32,
  parameter int CONN_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  cto_stream_if.sink                       in_i,
  cto_stream_if.source                     out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [cto_pkg::WaitW-1:0]   cfg_data_i
);
  import cto_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CONN_W = (CONN_BITS < ConnFieldW) ? CONN_BITS : ConnFieldW;
  localparam logic [CNT_W-1:0] FullC = CNT_W'(CAPACITY);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SAdd   = 5'b00010,
    STick  = 5'b00100,
    SDel   = 5'b01000,
    SClear = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  removed_q, removed_d;
  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] lim_q;
  logic [WaitW-1:0]  wait_q;
  logic              kick_q;
  logic [TimeW-1:0]  key_q, now_q;
  logic [CONN_W-1:0] conn_q;
  logic [SeqW-1:0]   seq_q;
  out_word_t         out_q, ow;
  logic              ovalid_q, emit;

  logic              accept, can_emit, full, tick_fire, tick_last, head_match;
  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  key_in;
  logic [CountW:0]   n_next;
  cell_ctrl_t        ctrl;
  logic [CONN_W-1:0] new_conn;
  logic [TimeW-1:0]  head_exp, head_exp_d;
  logic [CONN_W-1:0] head_conn;
  logic [SeqW-1:0]   head_seq;

  cto_chain #(
    .CAPACITY (CAPACITY),
    .CONN_W   (CONN_W),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .cnt_i        (cnt_q),
    .new_conn_i   (new_conn),
    .head_exp_o   (head_exp),
    .head_conn_o  (head_conn),
    .head_seq_o   (head_seq),
    .head_exp_d_o (head_exp_d)
  );

  // handshake
  assign in_i.ready  = (state_q == SIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign can_emit    = !ovalid_q || out_o.ready;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = out_q;

  // saturating expiry of the incoming word
  assign sum    = {1'b0, in_i.data.now} + (TimeW+1)'(wait_q);
  assign key_in = sum[TimeW] ? '1 : sum[TimeW-1:0];

  assign full       = (cnt_q == FullC);
  assign head_match = (head_conn == conn_q);
  assign tick_fire  = (n_q < lim_q) && (cnt_q != '0) && (head_exp <= now_q);
  assign n_next     = {1'b0, n_q} + (CountW+1)'(1);

  // command sequencing
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    removed_d = removed_q;
    n_d       = n_q;
    emit      = 1'b0;
    tick_last = 1'b1;
    ctrl      = '{mode: ModeHold, tail_only: 1'b0, key: key_q, seq: seq_q};
    new_conn  = conn_q;
    ow        = '0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          case (cmd_e'(in_i.data.cmd))
            CmdAdd:   state_d = SAdd;
            CmdTick:  state_d = STick;
            CmdDel:   state_d = SDel;
            default:  state_d = SClear;
          endcase
          rem_d     = cnt_q;
          removed_d = '0;
          n_d       = '0;
        end
      end
      SAdd: begin
        if (can_emit) begin
          emit    = 1'b1;
          state_d = SIdle;
          if (full) begin
            ow.status = StFull;
          end else begin
            ctrl.mode = ModeIns;
            cnt_d     = cnt_q + CNT_W'(1);
            ow.status = StAdded;
          end
        end
      end
      STick: begin
        if (can_emit) begin
          emit = 1'b1;
          if (tick_fire) begin
            ctrl.mode     = kick_q ? ModePop : ModePopIns;
            ctrl.seq      = head_seq;
            new_conn      = head_conn;
            cnt_d         = kick_q ? cnt_q - CNT_W'(1) : cnt_q;
            n_d           = n_next[CountW-1:0];
            ow.status     = StExpired;
            ow.out_conn   = ConnFieldW'(head_conn);
            ow.out_seq    = head_seq;
            ow.out_expiry = head_exp;
            // stop when the next head would not fire
            tick_last = (n_next >= {1'b0, lim_q}) || (cnt_d == '0) ||
                        (head_exp_d > now_q);
            if (tick_last) begin
              state_d = SIdle;
            end
          end else begin
            ow.status = StNone;
            state_d   = SIdle;
          end
        end
      end
      SDel: begin
        if (rem_q != '0) begin
          // rotate the head out; keep it at the tail unless it matches
          rem_d    = rem_q - CNT_W'(1);
          ctrl.key = head_exp;
          ctrl.seq = head_seq;
          new_conn = head_conn;
          if (head_match) begin
            ctrl.mode = ModePop;
            cnt_d     = cnt_q - CNT_W'(1);
            removed_d = removed_q + CNT_W'(1);
          end else begin
            ctrl.mode      = ModePopIns;
            ctrl.tail_only = 1'b1;
          end
        end else if (can_emit) begin
          emit             = 1'b1;
          ow.status        = StDeleted;
          ow.removed_count = CountW'(removed_q);
          state_d          = SIdle;
        end
      end
      SClear: begin
        if (can_emit) begin
          emit      = 1'b1;
          cnt_d     = '0;
          ow.status = StCleared;
          state_d   = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    ow.held_count = CountW'(cnt_d);
    ow.earliest   = (cnt_d != '0) ? head_exp_d : '0;
    ow.last       = tick_last;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      rem_q     <= '0;
      removed_q <= '0;
      n_q       <= '0;
      ovalid_q  <= 1'b0;
      wait_q    <= WaitW'(20);
      kick_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      removed_q <= removed_d;
      n_q       <= n_d;
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWaitTime: wait_q <= cfg_data_i;
          RegKick:     kick_q <= cfg_data_i[0];
          default:     wait_q <= wait_q;
        endcase
      end
    end
  end

  // latched command word and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= key_in;
      now_q <= in_i.data.now;
      conn_q <= in_i.data.conn_id[CONN_W-1:0];
      seq_q <= in_i.data.conn_seq;
      lim_q <= (32'(cnt_q) > 32'(MaxResults)) ? CountW'(MaxResults) : CountW'(cnt_q);
    end
    if (emit) begin
      out_q <= ow;
    end
  end
endmodule
`default_nettype wire
